[rtl/core/nha_pkg.sv]
// ----------------------------------------------------------------------------
// nha_pkg
// Shared widths, defaults and the degree factor table of the net half
// perimeter wirelength accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package nha_pkg;

  // item field widths
  localparam int CELL_XY_W   = 31;
  localparam int CELL_SIZE_W = 20;
  localparam int PIN_OFS_W   = 22;
  localparam int EXTENT_W    = 32;
  localparam int WL_W        = 33;
  localparam int WT_W        = 35;
  localparam int DEG_W       = 6;
  localparam int SUM_W       = 48;

  // position of one pin before clamping, half units
  localparam int RAW_W       = 33;

  // degree factors, q2.16
  localparam int FACTOR_W    = 18;
  localparam int FRAC_BITS   = 16;

  localparam logic [DEG_W-1:0] COUNT_MAX = {DEG_W{1'b1}};

  // parameter defaults
  localparam int DEF_FACTOR_ENTRIES = 51;
  localparam int DEF_COORD_BITS     = 33;
  localparam int DEF_TOTAL_BITS     = 48;

  function automatic logic [FACTOR_W-1:0] degree_factor(input logic [DEG_W-1:0] idx);
    logic [FACTOR_W-1:0] f;
    case (idx)
      6'd0:    f = 18'd0;
      6'd1:    f = 18'd65536;
      6'd2:    f = 18'd65536;
      6'd3:    f = 18'd65536;
      6'd4:    f = 18'd70962;
      6'd5:    f = 18'd75602;
      6'd6:    f = 18'd79993;
      6'd7:    f = 18'd84038;
      6'd8:    f = 18'd87720;
      6'd9:    f = 18'd91691;
      6'd10:   f = 18'd94979;
      6'd11:   f = 18'd98132;
      6'd12:   f = 18'd101286;
      6'd13:   f = 18'd104439;
      6'd14:   f = 18'd107593;
      6'd15:   f = 18'd110747;
      6'd16:   f = 18'd113402;
      6'd17:   f = 18'd116057;
      6'd18:   f = 18'd118713;
      6'd19:   f = 18'd121368;
      6'd20:   f = 18'd124023;
      6'd21:   f = 18'd126407;
      6'd22:   f = 18'd128790;
      6'd23:   f = 18'd131174;
      6'd24:   f = 18'd133557;
      6'd25:   f = 18'd135941;
      6'd26:   f = 18'd138026;
      6'd27:   f = 18'd140112;
      6'd28:   f = 18'd142198;
      6'd29:   f = 18'd144283;
      6'd30:   f = 18'd146369;
      6'd31:   f = 18'd148414;
      6'd32:   f = 18'd150460;
      6'd33:   f = 18'd152505;
      6'd34:   f = 18'd154550;
      6'd35:   f = 18'd156595;
      6'd36:   f = 18'd158510;
      6'd37:   f = 18'd160425;
      6'd38:   f = 18'd162340;
      6'd39:   f = 18'd164256;
      6'd40:   f = 18'd166171;
      6'd41:   f = 18'd167835;
      6'd42:   f = 18'd169499;
      6'd43:   f = 18'd171163;
      6'd44:   f = 18'd172827;
      6'd45:   f = 18'd174491;
      6'd46:   f = 18'd176206;
      6'd47:   f = 18'd177920;
      6'd48:   f = 18'd179635;
      6'd49:   f = 18'd181350;
      default: f = 18'd183064;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

[rtl/core/nha_pin_if.sv]
// ----------------------------------------------------------------------------
// nha_pin_if
// Valid/ready channel that carries one pin item.
// ----------------------------------------------------------------------------
`default_nettype none

interface nha_pin_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [nha_pkg::CELL_XY_W-1:0]       cell_x;
  logic signed [nha_pkg::CELL_XY_W-1:0]       cell_y;
  logic        [nha_pkg::CELL_SIZE_W-1:0]     cell_width;
  logic        [nha_pkg::CELL_SIZE_W-1:0]     cell_height;
  logic signed [nha_pkg::PIN_OFS_W-1:0]       pin_dx;
  logic signed [nha_pkg::PIN_OFS_W-1:0]       pin_dy;
  logic                                       last_pin;
  logic                                       restart_totals;

  modport source (
    output valid, cell_x, cell_y, cell_width, cell_height, pin_dx, pin_dy,
           last_pin, restart_totals,
    input  ready
  );

  modport sink (
    input  valid, cell_x, cell_y, cell_width, cell_height, pin_dx, pin_dy,
           last_pin, restart_totals,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/nha_result_if.sv]
// ----------------------------------------------------------------------------
// nha_result_if
// Valid/ready channel that carries one net result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface nha_result_if;
  logic                            valid;
  logic                            ready;
  logic [nha_pkg::EXTENT_W-1:0]    box_width;
  logic [nha_pkg::EXTENT_W-1:0]    box_height;
  logic [nha_pkg::WL_W-1:0]        net_wirelength;
  logic [nha_pkg::WT_W-1:0]        net_weighted;
  logic [nha_pkg::DEG_W-1:0]       net_degree;
  logic [nha_pkg::SUM_W-1:0]       sum_wirelength;
  logic [nha_pkg::SUM_W-1:0]       sum_weighted;
  logic [nha_pkg::SUM_W-1:0]       sum_x_part;
  logic [nha_pkg::SUM_W-1:0]       sum_y_part;

  modport source (
    output valid, box_width, box_height, net_wirelength, net_weighted, net_degree,
           sum_wirelength, sum_weighted, sum_x_part, sum_y_part,
    input  ready
  );

  modport sink (
    input  valid, box_width, box_height, net_wirelength, net_weighted, net_degree,
           sum_wirelength, sum_weighted, sum_x_part, sum_y_part,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/net_hpwl_accumulator_core.sv]
// ----------------------------------------------------------------------------
// net_hpwl_accumulator_core
// Streams the pins of one net at a time, grows the net's bounding box and
// gives width, height, pin count, half perimeter, degree-weighted half perimeter and
// saturating running totals on each last pin.
// ----------------------------------------------------------------------------
// One pin is taken every clock cycle while the result side keeps up; the
// figure is set by the bounding box register, which folds in one pin per
// cycle. A net's result passes through these registers once its last pin
// is accepted: pin position and clamp at the accepting edge, then box
// update, extent, half perimeter, degree factor multiply, and the running
// totals in the output register. Pins keep flowing while a result waits; a
// last pin stalls only while the pipeline behind the box is full.
// use_pin_offsets must be written through cfg_wen/cfg_wdata only while the
// block is idle, not enforced; coordinates are half units, factors q2.16.
// ----------------------------------------------------------------------------
`default_nettype none

module net_hpwl_accumulator_core #(
  parameter int FACTOR_ENTRIES = nha_pkg::DEF_FACTOR_ENTRIES,
  parameter int COORD_BITS     = nha_pkg::DEF_COORD_BITS,
  parameter int TOTAL_BITS     = nha_pkg::DEF_TOTAL_BITS
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_wen,
  input  wire logic   cfg_wdata,
  nha_pin_if.sink     pin_in,
  nha_result_if.source result_out
);
  import nha_pkg::*;

  localparam int CW    = (COORD_BITS > RAW_W) ? COORD_BITS : RAW_W;
  localparam int EW    = (COORD_BITS + 1 > EXTENT_W + 2) ? COORD_BITS + 1 : EXTENT_W + 2;
  localparam int PROD_W = WL_W + FACTOR_W;
  localparam int ADD_W = (TOTAL_BITS > WT_W) ? TOTAL_BITS + 1 : WT_W + 1;

  localparam logic signed [COORD_BITS-1:0] COORD_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_LO = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [DEG_W-1:0]             LAST_IDX = DEG_W'(FACTOR_ENTRIES - 1);
  localparam logic [TOTAL_BITS-1:0]        TOTAL_MAX = {TOTAL_BITS{1'b1}};

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [TOTAL_BITS-1:0]        total_t;

  function automatic logic [EXTENT_W-1:0] extent(input coord_t lo, input coord_t hi);
    logic signed [EW-1:0] d;
    logic [EXTENT_W-1:0]  r;
    d = EW'(hi) - EW'(lo);
    if (d[EW-1] || d == '0) begin
      r = '0;
    end else if (d[EW-1:EXTENT_W] != '0) begin
      r = '1;
    end else begin
      r = d[EXTENT_W-1:0];
    end
    return r;
  endfunction

  function automatic total_t sat_add(input total_t a, input logic [WT_W-1:0] b);
    logic [ADD_W-1:0] s;
    total_t           r;
    s = ADD_W'(a) + ADD_W'(b);
    if (s > ADD_W'(TOTAL_MAX)) begin
      r = TOTAL_MAX;
    end else begin
      r = s[TOTAL_BITS-1:0];
    end
    return r;
  endfunction

  function automatic coord_t clamp(input logic signed [RAW_W-1:0] v);
    logic signed [CW-1:0] e;
    coord_t               r;
    e = CW'(v);
    if (e > CW'(COORD_HI)) begin
      r = COORD_HI;
    end else if (e < CW'(COORD_LO)) begin
      r = COORD_LO;
    end else begin
      r = COORD_BITS'(e);
    end
    return r;
  endfunction

  // configuration
  logic use_pin_offsets;

  // pin stage
  logic   p_valid, p_last, p_restart;
  coord_t p_x, p_y;

  // box state
  coord_t           box_min_x, box_max_x, box_min_y, box_max_y;
  logic [DEG_W-1:0] pin_count;
  logic             restart_seen;

  // closed net stage
  logic             n_valid, n_restart;
  coord_t           n_min_x, n_max_x, n_min_y, n_max_y;
  logic [DEG_W-1:0] n_count;

  // extent stage
  logic                e_valid, e_restart;
  logic [EXTENT_W-1:0] e_w, e_h;
  logic [FACTOR_W-1:0] e_factor;
  logic [DEG_W-1:0]    e_count;

  // half perimeter stage
  logic                l_valid, l_restart;
  logic [EXTENT_W-1:0] l_w, l_h;
  logic [WL_W-1:0]     l_wl;
  logic [FACTOR_W-1:0] l_factor;
  logic [DEG_W-1:0]    l_count;

  // weighted stage
  logic                m_valid, m_restart;
  logic [EXTENT_W-1:0] m_w, m_h;
  logic [WL_W-1:0]     m_wl;
  logic [WT_W-1:0]     m_wt;
  logic [DEG_W-1:0]    m_count;

  // output register and totals
  logic                o_valid;
  logic [EXTENT_W-1:0] o_w, o_h;
  logic [WL_W-1:0]     o_wl;
  logic [WT_W-1:0]     o_wt;
  logic [DEG_W-1:0]    o_count;
  total_t              total_length, total_weighted_length, total_width, total_height;

  // flow control
  logic out_load, m_free, l_adv, l_free, e_adv, e_free, n_adv, n_free, p_adv, p_free;

  always_comb begin
    out_load = m_valid && (!o_valid || result_out.ready);
    m_free   = !m_valid || out_load;
    l_adv    = l_valid && m_free;
    l_free   = !l_valid || l_adv;
    e_adv    = e_valid && l_free;
    e_free   = !e_valid || e_adv;
    n_adv    = n_valid && e_free;
    n_free   = !n_valid || n_adv;
    p_adv    = p_valid && (!p_last || n_free);
    p_free   = !p_valid || p_adv;
  end

  assign pin_in.ready = p_free;

  // pin position in half units
  logic signed [RAW_W-1:0] x_raw, y_raw;
  logic                    pin_take;

  always_comb begin
    pin_take = pin_in.valid && p_free;
    if (use_pin_offsets) begin
      x_raw = RAW_W'($signed({pin_in.cell_x, 1'b0})) + RAW_W'(pin_in.pin_dx);
      y_raw = RAW_W'($signed({pin_in.cell_y, 1'b0})) + RAW_W'(pin_in.pin_dy);
    end else begin
      x_raw = RAW_W'($signed({pin_in.cell_x, 1'b0})) + RAW_W'($signed({1'b0, pin_in.cell_width}));
      y_raw = RAW_W'($signed({pin_in.cell_y, 1'b0})) + RAW_W'($signed({1'b0, pin_in.cell_height}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_pin_offsets <= 1'b0;
    end else if (cfg_wen) begin
      use_pin_offsets <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_free) begin
      p_valid <= pin_in.valid;
    end
    if (pin_take) begin
      p_x       <= clamp(x_raw);
      p_y       <= clamp(y_raw);
      p_last    <= pin_in.last_pin;
      p_restart <= pin_in.restart_totals;
    end
  end

  // bounding box update
  coord_t           min_x_next, max_x_next, min_y_next, max_y_next;
  logic [DEG_W-1:0] count_next;

  always_comb begin
    min_x_next = (p_x < box_min_x) ? p_x : box_min_x;
    max_x_next = (p_x > box_max_x) ? p_x : box_max_x;
    min_y_next = (p_y < box_min_y) ? p_y : box_min_y;
    max_y_next = (p_y > box_max_y) ? p_y : box_max_y;
    count_next = (pin_count < COUNT_MAX) ? pin_count + DEG_W'(1) : pin_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_x    <= COORD_HI;
      box_max_x    <= COORD_LO;
      box_min_y    <= COORD_HI;
      box_max_y    <= COORD_LO;
      pin_count    <= '0;
      restart_seen <= 1'b0;
    end else if (p_adv) begin
      if (p_last) begin
        box_min_x    <= COORD_HI;
        box_max_x    <= COORD_LO;
        box_min_y    <= COORD_HI;
        box_max_y    <= COORD_LO;
        pin_count    <= '0;
        restart_seen <= 1'b0;
      end else begin
        box_min_x    <= min_x_next;
        box_max_x    <= max_x_next;
        box_min_y    <= min_y_next;
        box_max_y    <= max_y_next;
        pin_count    <= count_next;
        restart_seen <= restart_seen || p_restart;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid <= 1'b0;
    end else if (n_free) begin
      n_valid <= p_adv && p_last;
    end
    if (n_free && p_adv && p_last) begin
      n_min_x   <= min_x_next;
      n_max_x   <= max_x_next;
      n_min_y   <= min_y_next;
      n_max_y   <= max_y_next;
      n_count   <= count_next;
      n_restart <= restart_seen || p_restart;
    end
  end

  // extents and degree factor
  logic [DEG_W-1:0] factor_idx;
  assign factor_idx = (n_count < LAST_IDX) ? n_count : LAST_IDX;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_free) begin
      e_valid <= n_valid;
    end
    if (n_adv) begin
      e_w       <= extent(n_min_x, n_max_x);
      e_h       <= extent(n_min_y, n_max_y);
      e_factor  <= degree_factor(factor_idx);
      e_count   <= n_count;
      e_restart <= n_restart;
    end
  end

  // half perimeter
  always_ff @(posedge clk) begin
    if (rst) begin
      l_valid <= 1'b0;
    end else if (l_free) begin
      l_valid <= e_valid;
    end
    if (e_adv) begin
      l_w       <= e_w;
      l_h       <= e_h;
      l_wl      <= WL_W'(e_w) + WL_W'(e_h);
      l_factor  <= e_factor;
      l_count   <= e_count;
      l_restart <= e_restart;
    end
  end

  // degree weighting
  logic [PROD_W-1:0] prod;
  assign prod = PROD_W'(l_wl) * PROD_W'(l_factor);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_free) begin
      m_valid <= l_valid;
    end
    if (l_adv) begin
      m_w       <= l_w;
      m_h       <= l_h;
      m_wl      <= l_wl;
      m_wt      <= prod[PROD_W-1:FRAC_BITS];
      m_count   <= l_count;
      m_restart <= l_restart;
    end
  end

  // running totals, cleared on restart before this net is added
  total_t base_length, base_weighted, base_width, base_height;

  always_comb begin
    base_length   = m_restart ? '0 : total_length;
    base_weighted = m_restart ? '0 : total_weighted_length;
    base_width    = m_restart ? '0 : total_width;
    base_height   = m_restart ? '0 : total_height;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid               <= 1'b0;
      total_length          <= '0;
      total_weighted_length <= '0;
      total_width           <= '0;
      total_height          <= '0;
    end else begin
      if (out_load) begin
        o_valid               <= 1'b1;
        total_length          <= sat_add(base_length, WT_W'(m_wl));
        total_weighted_length <= sat_add(base_weighted, m_wt);
        total_width           <= sat_add(base_width, WT_W'(m_w));
        total_height          <= sat_add(base_height, WT_W'(m_h));
      end else if (result_out.ready) begin
        o_valid <= 1'b0;
      end
    end
    if (out_load) begin
      o_w     <= m_w;
      o_h     <= m_h;
      o_wl    <= m_wl;
      o_wt    <= m_wt;
      o_count <= m_count;
    end
  end

  assign result_out.valid          = o_valid;
  assign result_out.box_width      = o_w;
  assign result_out.box_height     = o_h;
  assign result_out.net_wirelength = o_wl;
  assign result_out.net_weighted   = o_wt;
  assign result_out.net_degree     = o_count;
  assign result_out.sum_wirelength = SUM_W'(total_length);
  assign result_out.sum_weighted   = SUM_W'(total_weighted_length);
  assign result_out.sum_x_part     = SUM_W'(total_width);
  assign result_out.sum_y_part     = SUM_W'(total_height);

endmodule

`default_nettype wire

[dv/net_hpwl_accumulator_core_tb.sv]
// ----------------------------------------------------------------------------
// net_hpwl_accumulator_core_tb
// Feeds nets of pins through the pin channel in center and pin offset mode,
// predicts each net's bounding box, weighted half perimeter and running
// totals, and checks every result item in order. Both channels idle at
// random; a full-rate stretch of maximum-extent nets runs with no gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module net_hpwl_accumulator_core_tb;
  import nha_pkg::*;

  typedef struct packed {
    logic signed [CELL_XY_W-1:0]   cell_x;
    logic signed [CELL_XY_W-1:0]   cell_y;
    logic        [CELL_SIZE_W-1:0] cell_width;
    logic        [CELL_SIZE_W-1:0] cell_height;
    logic signed [PIN_OFS_W-1:0]   pin_dx;
    logic signed [PIN_OFS_W-1:0]   pin_dy;
    logic                          last_pin;
    logic                          restart_totals;
  } pin_t;

  typedef struct packed {
    logic [EXTENT_W-1:0] box_width;
    logic [EXTENT_W-1:0] box_height;
    logic [WL_W-1:0]     net_wirelength;
    logic [WT_W-1:0]     net_weighted;
    logic [DEG_W-1:0]    net_degree;
    logic [SUM_W-1:0]    sum_wirelength;
    logic [SUM_W-1:0]    sum_weighted;
    logic [SUM_W-1:0]    sum_x_part;
    logic [SUM_W-1:0]    sum_y_part;
  } net_result_t;

  localparam longint COORD_HI   = (longint'(1) << 32) - 1;
  localparam longint COORD_LO   = -(longint'(1) << 32);
  localparam longint EXTENT_CAP = (longint'(1) << 32) - 1;
  localparam longint TOTAL_CAP  = (longint'(1) << 48) - 1;
  localparam int     DEG_CAP    = 63;
  localparam int     LAST_ENTRY = 50;
  localparam int     SETTLE     = 20;
  localparam int     SAT_NETS   = 20;

  localparam logic signed [CELL_XY_W-1:0] CX_MAX = {1'b0, {(CELL_XY_W-1){1'b1}}};
  localparam logic signed [CELL_XY_W-1:0] CX_MIN = {1'b1, {(CELL_XY_W-1){1'b0}}};
  localparam logic [CELL_SIZE_W-1:0]      SZ_MAX = {CELL_SIZE_W{1'b1}};
  localparam logic signed [PIN_OFS_W-1:0] OFS_MAX = {1'b0, {(PIN_OFS_W-1){1'b1}}};
  localparam logic signed [PIN_OFS_W-1:0] OFS_MIN = {1'b1, {(PIN_OFS_W-1){1'b0}}};

  int unsigned deg_q16 [0:50] = '{
    0,
    65536, 65536, 65536, 70962, 75602,
    79993, 84038, 87720, 91691, 94979,
    98132, 101286, 104439, 107593, 110747,
    113402, 116057, 118713, 121368, 124023,
    126407, 128790, 131174, 133557, 135941,
    138026, 140112, 142198, 144283, 146369,
    148414, 150460, 152505, 154550, 156595,
    158510, 160425, 162340, 164256, 166171,
    167835, 169499, 171163, 172827, 174491,
    176206, 177920, 179635, 181350, 183064
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic cfg_wdata = 1'b0;

  nha_pin_if    pin_if ();
  nha_result_if res_if ();

  net_hpwl_accumulator_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .pin_in    (pin_if),
    .result_out(res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  bit     pin_mode;
  longint box_lo_x, box_hi_x, box_lo_y, box_hi_y;
  int     pins_seen;
  longint tot_len, tot_wt, tot_w, tot_h;

  pin_t        pin_q[$];
  net_result_t net_results_q[$];
  int          pins_outstanding = 0;
  int          mismatch_cnt = 0;
  bit          pin_taken = 1'b0;
  bit          quiet = 1'b0;
  int          pin_gap = 0;
  int          pin_calm = 0;
  int          res_stall = 0;
  int          res_calm = 0;
  pin_t        nxt_pin;

  function automatic longint clamp(input longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  function automatic longint span(input longint lo, input longint hi);
    if (hi <= lo) return 0;
    if (hi - lo > EXTENT_CAP) return EXTENT_CAP;
    return hi - lo;
  endfunction

  function automatic longint sat_add(input longint a, input longint b);
    return (a + b > TOTAL_CAP) ? TOTAL_CAP : a + b;
  endfunction

  task automatic clear_box();
    box_lo_x  = COORD_HI;
    box_hi_x  = COORD_LO;
    box_lo_y  = COORD_HI;
    box_hi_y  = COORD_LO;
    pins_seen = 0;
  endtask

  task automatic fold_pin(input pin_t p);
    longint px, py, w, h, wl, wt;
    int idx;
    net_result_t r;
    px = 2 * longint'($signed(p.cell_x));
    py = 2 * longint'($signed(p.cell_y));
    if (pin_mode) begin
      px = px + longint'($signed(p.pin_dx));
      py = py + longint'($signed(p.pin_dy));
    end else begin
      px = px + longint'(p.cell_width);
      py = py + longint'(p.cell_height);
    end
    px = clamp(px);
    py = clamp(py);
    if (p.restart_totals) begin
      tot_len = 0;
      tot_wt  = 0;
      tot_w   = 0;
      tot_h   = 0;
    end
    if (px < box_lo_x) box_lo_x = px;
    if (px > box_hi_x) box_hi_x = px;
    if (py < box_lo_y) box_lo_y = py;
    if (py > box_hi_y) box_hi_y = py;
    if (pins_seen < DEG_CAP) pins_seen++;
    if (p.last_pin) begin
      w   = span(box_lo_x, box_hi_x);
      h   = span(box_lo_y, box_hi_y);
      wl  = w + h;
      idx = (pins_seen < LAST_ENTRY) ? pins_seen : LAST_ENTRY;
      wt  = (wl * longint'(deg_q16[idx])) >>> FRAC_BITS;
      tot_len = sat_add(tot_len, wl);
      tot_wt  = sat_add(tot_wt, wt);
      tot_w   = sat_add(tot_w, w);
      tot_h   = sat_add(tot_h, h);
      r.box_width      = EXTENT_W'(w);
      r.box_height     = EXTENT_W'(h);
      r.net_wirelength = WL_W'(wl);
      r.net_weighted   = WT_W'(wt);
      r.net_degree     = DEG_W'(pins_seen);
      r.sum_wirelength = SUM_W'(tot_len);
      r.sum_weighted   = SUM_W'(tot_wt);
      r.sum_x_part     = SUM_W'(tot_w);
      r.sum_y_part     = SUM_W'(tot_h);
      net_results_q.push_back(r);
      clear_box();
    end
  endtask

  function automatic int pick_gap(inout int calm);
    int r;
    if (quiet) return 0;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // pin driver
  always @(negedge clk) begin
    if (rst) begin
      pin_if.valid <= 1'b0;
    end else if (!pin_if.valid || pin_taken) begin
      if (pin_gap > 0) begin
        pin_gap--;
        pin_if.valid <= 1'b0;
      end else if (pin_q.size() > 0) begin
        nxt_pin = pin_q.pop_front();
        pin_if.valid          <= 1'b1;
        pin_if.cell_x         <= nxt_pin.cell_x;
        pin_if.cell_y         <= nxt_pin.cell_y;
        pin_if.cell_width     <= nxt_pin.cell_width;
        pin_if.cell_height    <= nxt_pin.cell_height;
        pin_if.pin_dx         <= nxt_pin.pin_dx;
        pin_if.pin_dy         <= nxt_pin.pin_dy;
        pin_if.last_pin       <= nxt_pin.last_pin;
        pin_if.restart_totals <= nxt_pin.restart_totals;
        pin_gap = pick_gap(pin_calm);
      end else begin
        pin_if.valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (res_stall > 0) begin
      res_stall--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
      res_stall = pick_gap(res_calm);
    end
  end

  // monitor
  always @(posedge clk) begin
    net_result_t got, want;
    pin_t p;
    pin_taken = 1'b0;
    if (!rst) begin
      pin_taken = pin_if.valid && pin_if.ready;
      if (pin_taken) begin
        p.cell_x         = pin_if.cell_x;
        p.cell_y         = pin_if.cell_y;
        p.cell_width     = pin_if.cell_width;
        p.cell_height    = pin_if.cell_height;
        p.pin_dx         = pin_if.pin_dx;
        p.pin_dy         = pin_if.pin_dy;
        p.last_pin       = pin_if.last_pin;
        p.restart_totals = pin_if.restart_totals;
        fold_pin(p);
        pins_outstanding--;
      end
      if (res_if.valid && res_if.ready) begin
        got.box_width      = res_if.box_width;
        got.box_height     = res_if.box_height;
        got.net_wirelength = res_if.net_wirelength;
        got.net_weighted   = res_if.net_weighted;
        got.net_degree     = res_if.net_degree;
        got.sum_wirelength = res_if.sum_wirelength;
        got.sum_weighted   = res_if.sum_weighted;
        got.sum_x_part     = res_if.sum_x_part;
        got.sum_y_part     = res_if.sum_y_part;
        if (net_results_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result item with none pending: w %0d h %0d deg %0d",
                     $time, got.box_width, got.box_height, got.net_degree);
        end else begin
          want = net_results_q.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"%0t: bad result (exp/got) w %0d/%0d h %0d/%0d wl %0d/%0d ",
                        "wt %0d/%0d deg %0d/%0d swl %0d/%0d swt %0d/%0d sx %0d/%0d ",
                        "sy %0d/%0d"}, $time,
                       want.box_width, got.box_width, want.box_height, got.box_height,
                       want.net_wirelength, got.net_wirelength,
                       want.net_weighted, got.net_weighted,
                       want.net_degree, got.net_degree,
                       want.sum_wirelength, got.sum_wirelength,
                       want.sum_weighted, got.sum_weighted,
                       want.sum_x_part, got.sum_x_part,
                       want.sum_y_part, got.sum_y_part);
          end
        end
      end
    end
  end

  function automatic pin_t mk(input logic signed [CELL_XY_W-1:0] cx,
                              input logic signed [CELL_XY_W-1:0] cy,
                              input logic [CELL_SIZE_W-1:0] w,
                              input logic [CELL_SIZE_W-1:0] h,
                              input logic signed [PIN_OFS_W-1:0] dx,
                              input logic signed [PIN_OFS_W-1:0] dy,
                              input logic last, input logic rs);
    pin_t p;
    p.cell_x = cx;
    p.cell_y = cy;
    p.cell_width = w;
    p.cell_height = h;
    p.pin_dx = dx;
    p.pin_dy = dy;
    p.last_pin = last;
    p.restart_totals = rs;
    return p;
  endfunction

  function automatic pin_t rand_pin(input logic signed [CELL_XY_W-1:0] cx,
                                    input logic signed [CELL_XY_W-1:0] cy,
                                    input int spread);
    pin_t p;
    if (spread < 0) begin
      p.cell_x = CELL_XY_W'($urandom);
      p.cell_y = CELL_XY_W'($urandom);
    end else begin
      p.cell_x = cx + CELL_XY_W'($urandom_range(0, spread));
      p.cell_y = cy + CELL_XY_W'($urandom_range(0, spread));
    end
    p.cell_width  = ($urandom_range(0, 3) == 0) ? CELL_SIZE_W'($urandom)
                                                : CELL_SIZE_W'($urandom_range(0, 64));
    p.cell_height = ($urandom_range(0, 3) == 0) ? CELL_SIZE_W'($urandom)
                                                : CELL_SIZE_W'($urandom_range(0, 64));
    p.pin_dx = ($urandom_range(0, 3) == 0) ? PIN_OFS_W'($urandom)
                                           : PIN_OFS_W'($urandom_range(0, 128)) - 22'sd64;
    p.pin_dy = ($urandom_range(0, 3) == 0) ? PIN_OFS_W'($urandom)
                                           : PIN_OFS_W'($urandom_range(0, 128)) - 22'sd64;
    p.last_pin = 1'b0;
    p.restart_totals = ($urandom_range(0, 49) == 0);
    return p;
  endfunction

  task automatic push_pin(input pin_t p);
    pin_q.push_back(p);
    pins_outstanding++;
  endtask

  task automatic run_random(input int n_items, input bit long_first);
    int pushed, len, spread, r, i;
    logic signed [CELL_XY_W-1:0] cx, cy;
    pin_t p;
    pushed = 0;
    while (pushed < n_items) begin
      r = $urandom_range(0, 99);
      if (long_first && pushed == 0) len = $urandom_range(64, 72);
      else if (r < 80) len = $urandom_range(1, 6);
      else if (r < 96) len = $urandom_range(7, 30);
      else len = $urandom_range(40, 70);
      r = $urandom_range(0, 9);
      spread = (r < 6) ? 1000 : (r < 9) ? (1 << 20) : -1;
      cx = CELL_XY_W'($urandom);
      cy = CELL_XY_W'($urandom);
      for (i = 0; i < len; i++) begin
        p = rand_pin(cx, cy, spread);
        p.last_pin = (i == len - 1);
        push_pin(p);
      end
      pushed += len;
    end
  endtask

  task automatic drain();
    while (pins_outstanding != 0 || net_results_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_mode(input bit m);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    pin_mode = m;
  endtask

  initial begin
    #20_000_000;
    $display("net_hpwl_accumulator_core: mismatch");
    $finish;
  end

  initial begin
    int i;
    pin_if.valid = 1'b0;
    pin_if.cell_x = '0;
    pin_if.cell_y = '0;
    pin_if.cell_width = '0;
    pin_if.cell_height = '0;
    pin_if.pin_dx = '0;
    pin_if.pin_dy = '0;
    pin_if.last_pin = 1'b0;
    pin_if.restart_totals = 1'b0;
    res_if.ready = 1'b0;
    pin_mode = 1'b0;
    clear_box();
    tot_len = 0;
    tot_wt  = 0;
    tot_w   = 0;
    tot_h   = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // center mode
    write_mode(1'b0);
    push_pin(mk(CX_MIN, CX_MIN, '0, '0, OFS_MAX, OFS_MIN, 1'b1, 1'b1));
    push_pin(mk(CX_MAX, CX_MAX, SZ_MAX, SZ_MAX, OFS_MIN, OFS_MAX, 1'b1, 1'b0));
    push_pin(mk(CX_MIN, CX_MIN, '0, '0, '0, '0, 1'b0, 1'b0));
    push_pin(mk(CX_MAX, CX_MAX, SZ_MAX, SZ_MAX, '0, '0, 1'b1, 1'b0));
    push_pin(mk(CX_MAX, CX_MIN, '0, SZ_MAX, '0, '0, 1'b0, 1'b0));
    push_pin(mk(CX_MIN, CX_MAX, SZ_MAX, '0, '0, '0, 1'b1, 1'b0));
    for (i = 0; i < 3; i++)
      push_pin(mk(31'sd77, -31'sd5, 20'd9, 20'd9, '0, '0, i == 2, 1'b0));
    push_pin(mk(-31'sd10, 31'sd4, 20'd3, 20'd1, '0, '0, 1'b0, 1'b1));
    push_pin(mk(31'sd12, -31'sd8, 20'd0, 20'd6, '0, '0, 1'b0, 1'b0));
    push_pin(mk(-31'sd1, 31'sd0, 20'd2, 20'd2, '0, '0, 1'b0, 1'b0));
    push_pin(mk(31'sd3, 31'sd20, 20'd1, 20'd0, '0, '0, 1'b1, 1'b0));
    run_random(300, 1'b1);
    drain();

    // pin offset mode
    write_mode(1'b1);
    push_pin(mk(31'sd0, 31'sd0, SZ_MAX, SZ_MAX, OFS_MAX, OFS_MIN, 1'b1, 1'b0));
    push_pin(mk(CX_MAX, CX_MIN, '0, '0, OFS_MAX, OFS_MIN, 1'b0, 1'b0));
    push_pin(mk(CX_MIN, CX_MAX, '0, '0, OFS_MIN, OFS_MAX, 1'b1, 1'b0));
    push_pin(mk(31'sd0, 31'sd0, '0, '0, -22'sd1, 22'sd1, 1'b0, 1'b0));
    push_pin(mk(31'sd0, 31'sd0, '0, '0, 22'sd1, -22'sd1, 1'b1, 1'b0));
    for (i = 0; i < 5; i++)
      push_pin(mk(CELL_XY_W'(100 * i), CELL_XY_W'(-50 * i), 20'd7, 20'd7,
                  -22'sd3, 22'sd5, i == 4, i == 4));
    run_random(300, 1'b1);
    drain();

    // full-rate maximum-extent nets
    quiet = 1'b1;
    for (i = 0; i < SAT_NETS; i++) begin
      push_pin(mk(CX_MIN, CX_MIN, '0, '0, OFS_MIN, OFS_MIN, 1'b0, 1'b0));
      push_pin(mk(CX_MAX, CX_MAX, '0, '0, OFS_MAX, OFS_MAX, 1'b1, 1'b0));
    end
    drain();
    quiet = 1'b0;

    // back to center mode, totals restarted
    write_mode(1'b0);
    push_pin(mk(31'sd0, 31'sd0, 20'd3, 20'd5, '0, '0, 1'b1, 1'b1));
    run_random(60, 1'b0);
    drain();

    if (mismatch_cnt == 0) begin
      $display("net_hpwl_accumulator_core: match");
    end else begin
      $display("net_hpwl_accumulator_core: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/nha_pkg.sv
rtl/core/nha_pin_if.sv
rtl/core/nha_result_if.sv
rtl/core/net_hpwl_accumulator_core.sv
dv/net_hpwl_accumulator_core_tb.sv
